// ===== design/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants for the box overlap unit
// transfer payloads for box pairs and overlap results, axis codes
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int HALF_WIDTH  = COORD_WIDTH - 1;
    localparam int TOL_WIDTH   = 16;
    localparam int AXIS_WIDTH  = 2;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd7;

    localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_center_x;
        logic signed [COORD_WIDTH-1:0] a_center_y;
        logic signed [COORD_WIDTH-1:0] a_center_z;
        logic [HALF_WIDTH-1:0]         a_half_x;
        logic [HALF_WIDTH-1:0]         a_half_y;
        logic [HALF_WIDTH-1:0]         a_half_z;
        logic signed [COORD_WIDTH-1:0] b_center_x;
        logic signed [COORD_WIDTH-1:0] b_center_y;
        logic signed [COORD_WIDTH-1:0] b_center_z;
        logic [HALF_WIDTH-1:0]         b_half_x;
        logic [HALF_WIDTH-1:0]         b_half_y;
        logic [HALF_WIDTH-1:0]         b_half_z;
    } box_pair_t;

    typedef struct packed {
        logic                          overlapping;
        logic [AXIS_WIDTH-1:0]         normal_axis;
        logic                          normal_negative;
        logic signed [COORD_WIDTH-1:0] depth;
    } overlap_result_t;

endpackage

// ===== design/aabb_overlap_min_axis_unit.sv =====
// an input transfer reaches the result transfer by passing through all five register stages
// throughput: one box pair per cycle while m_ready does not stall, set by the five register stages
//   (bounds, clamp and tolerance, depth and overlap test, axis pick, saturate)
// a stall on m_ready holds each stage whose successor is full; nothing is lost
// reset (aresetn low, synchronous): all stage valid bits clear, tolerance loads 7
// ----------------------------------------------------------------------------
// aabb_overlap_min_axis_unit: box overlap test with least penetration axis
// pipelined per-axis overlap test, depth, axis choice and saturated depth
// ----------------------------------------------------------------------------
module aabb_overlap_min_axis_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [aabb_pkg::TOL_WIDTH-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  aabb_pkg::box_pair_t              s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output aabb_pkg::overlap_result_t        m_data
);
    import aabb_pkg::*;

    localparam int W1 = COORD_WIDTH + 1;
    localparam int W2 = COORD_WIDTH + 2;

    logic [TOL_WIDTH-1:0] tol_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy2, rdy3, rdy4, rdy5;

    // stage 1: box bounds
    logic signed [COORD_WIDTH-1:0] ac [3];
    logic signed [COORD_WIDTH-1:0] bc [3];
    logic [HALF_WIDTH-1:0]         ah [3];
    logic [HALF_WIDTH-1:0]         bh [3];
    logic signed [W1-1:0] amin_next [3], amax_next [3], bmin_next [3], bmax_next [3];
    logic                 neg_next [3];
    logic signed [W1-1:0] amin1_reg [3], amax1_reg [3], bmin1_reg [3], bmax1_reg [3];
    logic                 neg1_reg [3];

    // stage 2: clamped interval and tolerance bounds
    logic signed [W2-1:0] tol_ext;
    logic signed [W1-1:0] lo_next [3], hi_next [3];
    logic signed [W2-1:0] bmint_next [3], bmaxt_next [3];
    logic signed [W1-1:0] lo2_reg [3], hi2_reg [3], amin2_reg [3], amax2_reg [3];
    logic signed [W2-1:0] bmint2_reg [3], bmaxt2_reg [3];
    logic                 neg2_reg [3];

    // stage 3: depth and overlap per axis
    logic signed [W2-1:0] d_next [3];
    logic [2:0]           ov_next;
    logic signed [W2-1:0] d3_reg [3];
    logic                 all3_reg;
    logic                 neg3_reg [3];

    // stage 4: axis pick
    logic [AXIS_WIDTH-1:0] axis_next;
    logic [AXIS_WIDTH-1:0] axis4_reg;
    logic signed [W2-1:0]  depth4_reg;
    logic                  neg4_reg;
    logic                  all4_reg;

    // stage 5: saturate and output
    overlap_result_t res_next;
    overlap_result_t res5_reg;

    assign rdy5    = !v5_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign s_ready = !v1_reg || rdy2;

    assign m_valid = v5_reg;
    assign m_data  = res5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (s_ready) v1_reg <= s_valid;
            if (rdy2)    v2_reg <= v1_reg;
            if (rdy3)    v3_reg <= v2_reg;
            if (rdy4)    v4_reg <= v3_reg;
            if (rdy5)    v5_reg <= v4_reg;
        end
    end

    always_comb begin
        ac[0] = s_data.a_center_x;
        ac[1] = s_data.a_center_y;
        ac[2] = s_data.a_center_z;
        ah[0] = s_data.a_half_x;
        ah[1] = s_data.a_half_y;
        ah[2] = s_data.a_half_z;
        bc[0] = s_data.b_center_x;
        bc[1] = s_data.b_center_y;
        bc[2] = s_data.b_center_z;
        bh[0] = s_data.b_half_x;
        bh[1] = s_data.b_half_y;
        bh[2] = s_data.b_half_z;
        for (int i = 0; i < 3; i++) begin
            amin_next[i] = W1'(ac[i]) - $signed({2'b00, ah[i]});
            amax_next[i] = W1'(ac[i]) + $signed({2'b00, ah[i]});
            bmin_next[i] = W1'(bc[i]) - $signed({2'b00, bh[i]});
            bmax_next[i] = W1'(bc[i]) + $signed({2'b00, bh[i]});
            neg_next[i]  = ac[i] < bc[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            for (int i = 0; i < 3; i++) begin
                amin1_reg[i] <= amin_next[i];
                amax1_reg[i] <= amax_next[i];
                bmin1_reg[i] <= bmin_next[i];
                bmax1_reg[i] <= bmax_next[i];
                neg1_reg[i]  <= neg_next[i];
            end
        end
    end

    assign tol_ext = W2'(tol_reg);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lo_next[i]    = (amin1_reg[i] > bmin1_reg[i]) ? amin1_reg[i] : bmin1_reg[i];
            hi_next[i]    = (amax1_reg[i] < bmax1_reg[i]) ? amax1_reg[i] : bmax1_reg[i];
            bmint_next[i] = W2'(bmin1_reg[i]) - tol_ext;
            bmaxt_next[i] = W2'(bmax1_reg[i]) + tol_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            for (int i = 0; i < 3; i++) begin
                lo2_reg[i]    <= lo_next[i];
                hi2_reg[i]    <= hi_next[i];
                amin2_reg[i]  <= amin1_reg[i];
                amax2_reg[i]  <= amax1_reg[i];
                bmint2_reg[i] <= bmint_next[i];
                bmaxt2_reg[i] <= bmaxt_next[i];
                neg2_reg[i]   <= neg1_reg[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_next[i]  = W2'(hi2_reg[i]) - W2'(lo2_reg[i]);
            ov_next[i] = (W2'(amax2_reg[i]) > bmint2_reg[i]) &&
                         (W2'(amin2_reg[i]) < bmaxt2_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            for (int i = 0; i < 3; i++) begin
                d3_reg[i]   <= d_next[i];
                neg3_reg[i] <= neg2_reg[i];
            end
            all3_reg <= &ov_next;
        end
    end

    // later axis wins a tie
    always_comb begin
        if (d3_reg[0] < d3_reg[1]) begin
            axis_next = (d3_reg[0] < d3_reg[2]) ? AXIS_X : AXIS_Z;
        end else begin
            axis_next = (d3_reg[1] < d3_reg[2]) ? AXIS_Y : AXIS_Z;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            axis4_reg <= axis_next;
            all4_reg  <= all3_reg;
            unique case (axis_next)
                AXIS_X: begin
                    depth4_reg <= d3_reg[0];
                    neg4_reg   <= neg3_reg[0];
                end
                AXIS_Y: begin
                    depth4_reg <= d3_reg[1];
                    neg4_reg   <= neg3_reg[1];
                end
                default: begin
                    depth4_reg <= d3_reg[2];
                    neg4_reg   <= neg3_reg[2];
                end
            endcase
        end
    end

    always_comb begin
        res_next = '0;
        if (all4_reg) begin
            res_next.overlapping     = 1'b1;
            res_next.normal_axis     = axis4_reg;
            res_next.normal_negative = neg4_reg;
            if (depth4_reg[W2-1:COORD_WIDTH-1] == '0 ||
                depth4_reg[W2-1:COORD_WIDTH-1] == '1) begin
                res_next.depth = depth4_reg[COORD_WIDTH-1:0];
            end else if (depth4_reg[W2-1]) begin
                res_next.depth = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end else begin
                res_next.depth = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            res5_reg <= res_next;
        end
    end

`ifndef SYNTH
    // a miss reports all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.overlapping |->
            m_data.depth == '0 && m_data.normal_axis == AXIS_X && !m_data.normal_negative)
    else $error("non-overlapping result carries nonzero fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.normal_axis <= AXIS_Z)
    else $error("normal axis out of range");

    // an occupied stage with an empty successor always advances (checked here for stage 3)
    assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !v4_reg |=> v4_reg)
    else $error("pipeline bubble failed to advance");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
    else $error("pipeline not empty after reset");
`endif

endmodule
